[src/bsfp_pkg.sv]
// Shared types, codes and sizes for the byte stack with frame pointer.
package bsfp_pkg;

	localparam int DEPTH_DEF = 4096;
	localparam int OFFSET_W  = 12;
	localparam int VALUE_W   = 16;
	localparam int BYTE_W    = 8;
	localparam int OP_W      = 4;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BYTE  = 4'd0,
		OP_POP_BYTE   = 4'd1,
		OP_PEEK_BYTE  = 4'd2,
		OP_PUSH_WORD  = 4'd3,
		OP_POP_WORD   = 4'd4,
		OP_PEEK_WORD  = 4'd5,
		OP_BASE_BYTE  = 4'd6,
		OP_BASE_WORD  = 4'd7,
		OP_FRAME_BYTE = 4'd8,
		OP_FRAME_WORD = 4'd9,
		OP_SET_FP     = 4'd10,
		OP_FP_TO_TOP  = 4'd11,
		OP_FLUSH      = 4'd12
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_RANGE     = 3'd3,
		ST_READ_ONLY = 3'd4,
		ST_BAD_FRAME = 3'd5
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ENABLE = 2'd1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SECOND,
		S_FINISH
	} seq_state_t;

	typedef struct packed {
		logic       en;
		logic       we;
		logic [BYTE_W-1:0] wdata;
	} mem_ctl_t;

endpackage

[src/bsfp_ram.sv]
// Single-port byte memory with a registered read port.
module bsfp_ram
	import bsfp_pkg::*;
#(
	parameter int AW = 12
) (
	input  logic              clk,
	input  mem_ctl_t          ctl,
	input  logic [AW-1:0]     addr,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.we) begin
				mem[addr] <= ctl.wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

[src/byte_stack_with_frame_pointer.sv]
// Top level of the byte stack with stack pointer and frame pointer.
//
//   channel  direction  handshake            contents
//   in       to block   in_valid/in_ready    operation, push_value, offset, new_frame_value
//   out      from block out_valid/out_ready  read_data, status, pointers, empty/full flags
//   cfg      to block   cfg_write            cfg_index, cfg_data (capacity, write enable)
//
// A taken byte or non-memory item goes to the finish step, and a word item goes first
// through the second step, set by the single byte port of the stack memory: a word needs
// two accesses and the read port is registered. The result register loads in the finish
// step once free. Pointers update when the item is taken. Reset zeroes the stack pointer
// and result valid flag and sets the frame pointer to -1, the capacity to DEPTH and write
// enable on; stack bytes are not cleared. A stalled result holds the sequencer in its last
// step, and a new item is taken in that step as soon as the result register is free.
module byte_stack_with_frame_pointer
	import bsfp_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_W-1:0]          operation,
	input  logic [VALUE_W-1:0]       push_value,
	input  logic [OFFSET_W-1:0]      offset,
	input  logic signed [$clog2(DEPTH):0] new_frame_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [VALUE_W-1:0]       read_data,
	output logic [STATUS_W-1:0]      status,
	output logic [$clog2(DEPTH):0]   stack_pointer,
	output logic signed [$clog2(DEPTH):0] frame_pointer,
	output logic                     stack_empty,
	output logic                     is_full,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [$clog2(DEPTH):0]   cfg_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int PW = AW + 1;
	localparam int XW = ((PW > OFFSET_W) ? PW : OFFSET_W) + 2;
	localparam logic signed [XW-1:0] ONE   = 1;
	localparam logic signed [XW-1:0] TWO   = 2;
	localparam logic signed [XW-1:0] THREE = 3;
	localparam logic signed [XW-1:0] M_ONE = -1;
	localparam logic signed [XW-1:0] ZERO  = 0;

	seq_state_t state_q, state_n;

	logic [PW-1:0]        sp_q;
	logic signed [PW-1:0] fp_q;
	logic [PW-1:0]        cap_q;
	logic                 we_q;

	logic                 rd_q, wr_q, word_q;
	logic [AW-1:0]        addr_q;
	logic [BYTE_W-1:0]    hi_q, lo_q;
	status_t              st_q;

	logic                 out_valid_q;
	logic [VALUE_W-1:0]   data_q;
	status_t              status_q;
	logic [PW-1:0]        osp_q;
	logic signed [PW-1:0] ofp_q;
	logic                 empty_q, full_q;

	logic                 accept, can_load, load;
	logic [PW-1:0]        cap_eff;
	logic signed [XW-1:0] sp_x, fp_x, off_x, nf_x, cap_x;
	logic signed [XW-1:0] nsp_x, nfp_x, addr_x;
	logic                 rd_n, wr_n, word_n, mut;
	status_t              st_n;
	op_t                  op;

	mem_ctl_t             mem_ctl;
	logic [AW-1:0]        mem_addr;
	logic [BYTE_W-1:0]    mem_rdata;
	logic [VALUE_W-1:0]   data_n;

	assign op       = op_t'(operation);
	assign cap_eff  = (cap_q > PW'(DEPTH)) ? PW'(DEPTH) : cap_q;
	assign sp_x     = $signed(XW'(sp_q));
	assign fp_x     = XW'(fp_q);
	assign off_x    = $signed(XW'(offset));
	assign nf_x     = XW'(new_frame_value);
	assign cap_x    = $signed(XW'(cap_eff));
	assign can_load = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		mut    = (op == OP_PUSH_BYTE) || (op == OP_POP_BYTE) || (op == OP_PUSH_WORD) ||
			(op == OP_POP_WORD) || (op == OP_SET_FP) || (op == OP_FP_TO_TOP) ||
			(op == OP_FLUSH);
		st_n   = ST_OK;
		nsp_x  = sp_x;
		nfp_x  = fp_x;
		addr_x = ZERO;
		rd_n   = 1'b0;
		wr_n   = 1'b0;
		word_n = 1'b0;
		if (mut && !we_q) begin
			st_n = ST_READ_ONLY;
		end else begin
			case (op)
				OP_PUSH_BYTE: begin
					if (sp_x >= cap_x) st_n = ST_OVERFLOW;
					else begin
						wr_n   = 1'b1;
						addr_x = sp_x;
						nsp_x  = sp_x + ONE;
					end
				end
				OP_POP_BYTE, OP_PEEK_BYTE: begin
					if (sp_x <= fp_x + ONE) st_n = ST_UNDERFLOW;
					else begin
						rd_n   = 1'b1;
						addr_x = sp_x - ONE;
						if (op == OP_POP_BYTE) nsp_x = sp_x - ONE;
					end
				end
				OP_PUSH_WORD: begin
					if (sp_x + TWO > cap_x) st_n = ST_OVERFLOW;
					else begin
						wr_n   = 1'b1;
						word_n = 1'b1;
						addr_x = sp_x;
						nsp_x  = sp_x + TWO;
					end
				end
				OP_POP_WORD, OP_PEEK_WORD: begin
					if (sp_x < fp_x + THREE) st_n = ST_UNDERFLOW;
					else begin
						rd_n   = 1'b1;
						word_n = 1'b1;
						addr_x = sp_x - TWO;
						if (op == OP_POP_WORD) nsp_x = sp_x - TWO;
					end
				end
				OP_BASE_BYTE: begin
					if (off_x >= sp_x) st_n = ST_RANGE;
					else begin
						rd_n   = 1'b1;
						addr_x = off_x;
					end
				end
				OP_BASE_WORD: begin
					if (off_x + TWO > sp_x) st_n = ST_RANGE;
					else begin
						rd_n   = 1'b1;
						word_n = 1'b1;
						addr_x = off_x;
					end
				end
				OP_FRAME_BYTE: begin
					if (fp_x < ZERO || fp_x + off_x >= sp_x) st_n = ST_RANGE;
					else begin
						rd_n   = 1'b1;
						addr_x = fp_x + off_x;
					end
				end
				OP_FRAME_WORD: begin
					if (fp_x < ZERO || fp_x + off_x + TWO > sp_x) st_n = ST_RANGE;
					else begin
						rd_n   = 1'b1;
						word_n = 1'b1;
						addr_x = fp_x + off_x;
					end
				end
				OP_SET_FP: begin
					if (nf_x >= cap_x || nf_x < M_ONE) st_n = ST_BAD_FRAME;
					else nfp_x = nf_x;
				end
				OP_FP_TO_TOP: begin
					nfp_x = sp_x - ONE;
				end
				OP_FLUSH: begin
					nsp_x = fp_x + ONE;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_n = word_n ? S_SECOND : S_FINISH;
			end
			S_SECOND: begin
				state_n = S_FINISH;
			end
			S_FINISH: begin
				if (accept) state_n = word_n ? S_SECOND : S_FINISH;
				else if (can_load) state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Items never overlap at the memory port, so a read always sees earlier writes.
	always_comb begin
		in_ready      = 1'b0;
		load          = 1'b0;
		mem_ctl.en    = 1'b0;
		mem_ctl.we    = 1'b0;
		mem_ctl.wdata = push_value[BYTE_W-1:0];
		mem_addr      = addr_x[AW-1:0];
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_SECOND: begin
				mem_ctl.en    = 1'b1;
				mem_ctl.we    = wr_q;
				mem_ctl.wdata = hi_q;
				mem_addr      = addr_q + AW'(1);
			end
			S_FINISH: begin
				in_ready = can_load;
				load     = can_load;
			end
			default: begin
			end
		endcase
		if (accept) begin
			mem_ctl.en = rd_n || wr_n;
			mem_ctl.we = wr_n;
		end
	end

	bsfp_ram #(.AW(AW)) u_ram (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q    <= '0;
			fp_q    <= '1;
			cap_q   <= PW'(DEPTH);
			we_q    <= 1'b1;
		end else begin
			state_q <= state_n;
			if (accept) begin
				sp_q <= nsp_x[PW-1:0];
				fp_q <= nfp_x[PW-1:0];
			end
			if (cfg_write && cfg_index == CFG_CAPACITY) cap_q <= cfg_data;
			if (cfg_write && cfg_index == CFG_WRITE_ENABLE) we_q <= cfg_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= 1'b0;
			wr_q   <= 1'b0;
			word_q <= 1'b0;
		end else if (accept) begin
			rd_q   <= rd_n;
			wr_q   <= wr_n;
			word_q <= word_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= addr_x[AW-1:0];
			hi_q   <= push_value[VALUE_W-1:BYTE_W];
			st_q   <= st_n;
		end
		if (state_q == S_SECOND) lo_q <= mem_rdata;
	end

	always_comb begin
		data_n = '0;
		if (rd_q) begin
			if (word_q) data_n = {mem_rdata, lo_q};
			else data_n = {{(VALUE_W-BYTE_W){1'b0}}, mem_rdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q   <= data_n;
			status_q <= st_q;
			osp_q    <= sp_q;
			ofp_q    <= fp_q;
			empty_q  <= (sp_x == fp_x + ONE);
			full_q   <= (sp_x >= cap_x);
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = data_q;
	assign status        = status_q;
	assign stack_pointer = osp_q;
	assign frame_pointer = ofp_q;
	assign stack_empty   = empty_q;
	assign is_full       = full_q;

endmodule

[src/bsfp_checker.sv]
// Port-level checks for the byte stack, bound to its top level.
module bsfp_checker
	import bsfp_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [VALUE_W-1:0]       read_data,
	input logic [STATUS_W-1:0]      status,
	input logic [$clog2(DEPTH):0]   stack_pointer,
	input logic signed [$clog2(DEPTH):0] frame_pointer,
	input logic                     stack_empty
);

	localparam int PW = $clog2(DEPTH) + 1;

	logic signed [PW:0] sp_ext, fp_ext;

	assign sp_ext = $signed({1'b0, stack_pointer});
	assign fp_ext = (PW+1)'(frame_pointer);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
		else $error("A stalled result item changed.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> read_data == '0)
		else $error("A failed item carries read data.");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stack_empty == (sp_ext == fp_ext + (PW+1)'(1)))
		else $error("Empty flag disagrees with the pointers.");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stack_pointer <= PW'(DEPTH) && status <= ST_BAD_FRAME)
		else $error("Stack pointer or status out of range.");

endmodule

bind byte_stack_with_frame_pointer bsfp_checker #(.DEPTH(DEPTH)) u_bsfp_checker (.*);
